>>> src/pmon_pkg.sv
// Shared widths, constants and types of the pump rotation period monitor.
`default_nettype none

package pmon_pkg;

    localparam int TICK_W   = 14;
    localparam int PERIOD_W = 16;
    localparam int RPM_W    = 14;
    localparam int ROT_W    = 16;
    localparam int DELTA_W  = 17;
    localparam int STATE_W  = 3;
    localparam int PROD_W   = 23;

    localparam logic [TICK_W-1:0]   TICK_MAX    = 14'h3FFF;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 16'hFFFF;
    localparam logic [RPM_W-1:0]    RPM_MAX     = 14'h3FFF;
    localparam logic [PERIOD_W-1:0] MS_PER_MIN  = 16'd60000;
    localparam logic [ROT_W-1:0]    RUN_MIN_ROT = 16'd2;

    localparam int CLASS_SCALE = 100;
    localparam int SLOW_SCALE  = 101;
    localparam int FAST_SCALE  = 99;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_STARTED = 3'd1,
        ST_RUNNING = 3'd2,
        ST_SLOW    = 3'd3,
        ST_FAST    = 3'd4,
        ST_NORMAL  = 3'd5
    } run_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL,
        C_MEAS,
        C_CLS,
        C_DIV,
        C_HOLD
    } ctl_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> src/pmon_if.sv
// Valid/ready stream interfaces for marker samples and monitor results.
`default_nettype none

interface pmon_in_if;
    logic valid;
    logic ready;
    logic mode;
    logic marker;

    modport source (output valid, output mode, output marker, input ready);
    modport sink (input valid, input mode, input marker, output ready);
endinterface

interface pmon_out_if;
    import pmon_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATE_W-1:0]         pump_state;
    logic [PERIOD_W-1:0]        period_ms;
    logic [RPM_W-1:0]           rpm;
    logic [ROT_W-1:0]           rotation_count;
    logic signed [DELTA_W-1:0]  speed_delta;

    modport source (output valid, output pump_state, output period_ms, output rpm,
                    output rotation_count, output speed_delta, input ready);
    modport sink (input valid, input pump_state, input period_ms, input rpm,
                  input rotation_count, input speed_delta, output ready);
endinterface

`default_nettype wire

>>> src/pump_rotation_period_monitor.sv
// Top level: pump rotation period monitor on 5 ms ticks with a rotation marker.
// A start command or plain tick goes to C_HOLD and loads the result register once it is free.
// A tick that completes a rotation steps through the multiply, the period latch, the classification,
// the bit-serial divide, the rpm capture and the result load.
// Flow: one item in flight; a new item is accepted once the result register has loaded.
// The result register lets a new item in while the previous result waits.
// Reset (rst_n low, async) resets control, measurement and result-valid state; expected_reg resets to 0.
`default_nettype none

module pump_rotation_period_monitor #(
    parameter int TICK_MS = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pmon_pkg::PERIOD_W-1:0] cfg_wr_data,
    pmon_in_if.sink                       item,
    pmon_out_if.source                    result
);
    import pmon_pkg::*;

    localparam int MUL_RAW = TICK_W + $clog2(TICK_MS + 1);
    localparam int MUL_W   = (MUL_RAW > PERIOD_W + 1) ? MUL_RAW : PERIOD_W + 1;

    ctl_state_t          ctl_reg, ctl_next;
    run_state_t          run_reg, run_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [RPM_W-1:0]    rpm_reg, rpm_next;
    logic [ROT_W-1:0]    rot_reg, rot_next;
    logic                prev_reg, prev_next;
    logic                armed_reg, armed_next;
    logic [PERIOD_W-1:0] expected_reg;
    logic [MUL_W-1:0]    prod_reg;

    logic                      out_valid_reg, out_valid_next;
    run_state_t                out_state_reg;
    logic [PERIOD_W-1:0]       out_period_reg;
    logic [RPM_W-1:0]          out_rpm_reg;
    logic [ROT_W-1:0]          out_rot_reg;
    logic signed [DELTA_W-1:0] out_delta_reg;

    logic [TICK_W-1:0]   tick_inc;
    logic [PERIOD_W-1:0] period_sat;
    logic                class_load;
    logic                div_start;
    logic                out_load;
    run_state_t          speed_class;
    logic [PERIOD_W-1:0] quotient;
    div_status_t         div_status;

    pmon_class u_class (
        .clk         (clk),
        .load        (class_load),
        .period      (period_sat),
        .expected    (expected_reg),
        .speed_class (speed_class)
    );

    pmon_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (period_sat),
        .quotient (quotient),
        .status   (div_status)
    );

    always_comb
    begin
        tick_inc   = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 1'b1;
        period_sat = (prod_reg > MUL_W'(PERIOD_MAX)) ? PERIOD_MAX : prod_reg[PERIOD_W-1:0];
    end

    always_comb
    begin
        ctl_next    = ctl_reg;
        run_next    = run_reg;
        tick_next   = tick_reg;
        period_next = period_reg;
        rpm_next    = rpm_reg;
        rot_next    = rot_reg;
        prev_next   = prev_reg;
        armed_next  = armed_reg;
        class_load  = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;

        unique case (ctl_reg)
            C_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.mode)
                    begin
                        run_next = ST_STARTED;
                        ctl_next = C_HOLD;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                        if (run_reg == ST_STARTED && rot_reg > RUN_MIN_ROT)
                            run_next = ST_RUNNING;
                        prev_next = item.marker;
                        ctl_next  = C_HOLD;
                        // falling marker edge: first one arms, later ones measure
                        if (!item.marker && prev_reg)
                        begin
                            if (!armed_reg)
                            begin
                                armed_next = 1'b1;
                                tick_next  = '0;
                            end
                            else
                                ctl_next = C_MUL;
                        end
                    end
                end
            end
            C_MUL:
            begin
                ctl_next = C_MEAS;
            end
            C_MEAS:
            begin
                period_next = period_sat;
                rot_next    = rot_reg + 1'b1;
                tick_next   = '0;
                class_load  = 1'b1;
                div_start   = 1'b1;
                ctl_next    = C_CLS;
            end
            C_CLS:
            begin
                if (run_reg != ST_STARTED)
                    run_next = speed_class;
                ctl_next = C_DIV;
            end
            C_DIV:
            begin
                if (div_status.done && !div_status.busy)
                begin
                    rpm_next = (|quotient[PERIOD_W-1:RPM_W]) ? RPM_MAX : quotient[RPM_W-1:0];
                    ctl_next = C_HOLD;
                end
            end
            C_HOLD:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load = 1'b1;
                    ctl_next = C_IDLE;
                end
            end
            default:
            begin
                ctl_next = C_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= C_IDLE;
            run_reg       <= ST_IDLE;
            tick_reg      <= '0;
            period_reg    <= '0;
            rpm_reg       <= '0;
            rot_reg       <= '0;
            prev_reg      <= 1'b1;
            armed_reg     <= 1'b0;
            expected_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            run_reg       <= run_next;
            tick_reg      <= tick_next;
            period_reg    <= period_next;
            rpm_reg       <= rpm_next;
            rot_reg       <= rot_next;
            prev_reg      <= prev_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                expected_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_reg == C_MUL)
            prod_reg <= MUL_W'(tick_reg) * MUL_W'(TICK_MS);
        if (out_load)
        begin
            out_state_reg  <= run_reg;
            out_period_reg <= period_reg;
            out_rpm_reg    <= rpm_reg;
            out_rot_reg    <= rot_reg;
            out_delta_reg  <= $signed({1'b0, period_reg}) - $signed({1'b0, expected_reg});
        end
    end

    assign item.ready            = (ctl_reg == C_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.pump_state     = out_state_reg;
    assign result.period_ms      = out_period_reg;
    assign result.rpm            = out_rpm_reg;
    assign result.rotation_count = out_rot_reg;
    assign result.speed_delta    = out_delta_reg;

endmodule

`default_nettype wire

>>> src/pmon_div.sv
// Bit-serial restoring divider: 60000 / period, one quotient bit per cycle.
`default_nettype none

module pmon_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pmon_pkg::PERIOD_W-1:0]  divisor,
    output logic [pmon_pkg::PERIOD_W-1:0]  quotient,
    output pmon_pkg::div_status_t          status
);
    import pmon_pkg::*;

    localparam int CNT_W = $clog2(PERIOD_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] quo_reg;
    logic [PERIOD_W-1:0] dvs_reg;

    logic [PERIOD_W:0]   shifted;
    logic [PERIOD_W:0]   trial;
    logic                fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[PERIOD_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = ~trial[PERIOD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PERIOD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= MS_PER_MIN;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
            quo_reg <= {quo_reg[PERIOD_W-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

>>> src/pmon_class.sv
// Period classifier: exact cross products against the +-1% bands.
`default_nettype none

module pmon_class (
    input  logic                           clk,
    input  logic                           load,
    input  logic [pmon_pkg::PERIOD_W-1:0]  period,
    input  logic [pmon_pkg::PERIOD_W-1:0]  expected,
    output pmon_pkg::run_state_t           speed_class
);
    import pmon_pkg::*;

    logic [PROD_W-1:0] lhs_reg;
    logic [PROD_W-1:0] slow_lim_reg;
    logic [PROD_W-1:0] fast_lim_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lhs_reg      <= PROD_W'(period) * PROD_W'(CLASS_SCALE);
            slow_lim_reg <= PROD_W'(expected) * PROD_W'(SLOW_SCALE);
            fast_lim_reg <= PROD_W'(expected) * PROD_W'(FAST_SCALE);
        end
    end

    always_comb
    begin
        if (lhs_reg > slow_lim_reg)
            speed_class = ST_SLOW;
        else if (lhs_reg < fast_lim_reg)
            speed_class = ST_FAST;
        else
            speed_class = ST_NORMAL;
    end

endmodule

`default_nettype wire

>>> src/pmon_checker.sv
// Port-level checks on the monitor's result stream, bound to the top level.
`default_nettype none

module pmon_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [pmon_pkg::STATE_W-1:0]  pump_state,
    input logic [pmon_pkg::PERIOD_W-1:0] period_ms,
    input logic [pmon_pkg::ROT_W-1:0]    rotation_count
);
    import pmon_pkg::*;

    logic             out_xfer;
    logic [ROT_W-1:0] last_rot_reg;
    logic [ROT_W-1:0] last_rot_inc;

    assign out_xfer     = out_valid && out_ready;
    assign last_rot_inc = last_rot_reg + 1'b1;

    // track the count seen at the previous result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_rot_reg <= '0;
        else if (out_xfer)
            last_rot_reg <= rotation_count;
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before transfer");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pump_state) && $stable(period_ms)
                                    && $stable(rotation_count))
        else $error("result payload changed while stalled");

    a_rot_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (rotation_count == last_rot_reg) || (rotation_count == last_rot_inc))
        else $error("rotation count moved by more than one between transfers");

    a_meas_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && (rotation_count != last_rot_reg) |->
            (period_ms != '0) && (pump_state != ST_IDLE) && (pump_state != ST_RUNNING))
        else $error("measured rotation with zero period or unclassified state");

endmodule

bind pump_rotation_period_monitor pmon_checker u_pmon_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .pump_state     (result.pump_state),
    .period_ms      (result.period_ms),
    .rotation_count (result.rotation_count)
);

`default_nettype wire
